// ===== sv/sac_pkg.sv =====
package sac_pkg;

  localparam int NUM_CLASSES     = 14;
  localparam int SLABS_PER_CLASS = 4;
  localparam int TOTAL_SLABS     = NUM_CLASSES * SLABS_PER_CLASS;
  localparam int SLAB_W          = 6;   // slab number, address bits 21:16
  localparam int CLS_W           = 4;
  localparam int WORD_W          = 7;   // 128 bitmap words per slab
  localparam int SLOT_W          = 13;
  localparam int HWM_W           = 8;
  localparam int OFF_W           = 16;
  localparam int STRIDE_W        = 15;
  localparam logic [15:0] FIRST_BLOCK = 16'd1032;   // header plus slot tag
  localparam logic [15:0] MAX_BLOCK   = 16'd16384;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLAB  = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic                 is_free;
    logic                 reject;
    status_t              rej_status;
    logic [CLS_W-1:0]     cls;
    logic [SLAB_W-1:0]    slab;
    logic [OFF_W-1:0]     blk_off;  // slab offset minus first block offset
  } cmd_t;

  function automatic logic [STRIDE_W-1:0] stride_of(input logic [CLS_W-1:0] cls);
    stride_of = (STRIDE_W'(2) << cls) + STRIDE_W'(8);
  endfunction

  // Slots per slab for each class: (64 KiB - 1 KiB) / stride.
  function automatic logic [SLOT_W-1:0] slot_count(input logic [CLS_W-1:0] cls);
    case (cls)
      4'd0:    slot_count = 13'd6451;
      4'd1:    slot_count = 13'd5376;
      4'd2:    slot_count = 13'd4032;
      4'd3:    slot_count = 13'd2688;
      4'd4:    slot_count = 13'd1612;
      4'd5:    slot_count = 13'd896;
      4'd6:    slot_count = 13'd474;
      4'd7:    slot_count = 13'd244;
      4'd8:    slot_count = 13'd124;
      4'd9:    slot_count = 13'd62;
      4'd10:   slot_count = 13'd31;
      4'd11:   slot_count = 13'd15;
      4'd12:   slot_count = 13'd7;
      4'd13:   slot_count = 13'd3;
      default: slot_count = 13'd0;
    endcase
  endfunction

endpackage

// ===== sv/sac_front.sv =====
module sac_front (
  input  logic                   req_type,
  input  logic [15:0]            req_size,
  input  logic [21:0]            free_address,
  output sac_pkg::cmd_t          cmd
);

  logic [sac_pkg::CLS_W-1:0] acls;
  logic [sac_pkg::SLAB_W-1:0] fslab;
  logic [sac_pkg::OFF_W-1:0]  foff;
  logic bad_size;
  logic bad_free;

  // class = number of block sizes below the request
  always_comb begin
    acls = '0;
    for (int c = 0; c < sac_pkg::NUM_CLASSES; c++) begin
      if ({1'b0, req_size} > (17'd2 << c)) begin
        acls = acls + 4'd1;
      end
    end
  end

  assign fslab    = free_address[21:16];
  assign foff     = free_address[15:0];
  assign bad_size = (req_size == 16'd0) || (req_size > sac_pkg::MAX_BLOCK);
  assign bad_free = (fslab >= sac_pkg::SLAB_W'(sac_pkg::TOTAL_SLABS)) ||
                    (foff < sac_pkg::FIRST_BLOCK);

  always_comb begin
    cmd.is_free    = req_type;
    cmd.slab       = fslab;
    cmd.blk_off    = foff - sac_pkg::FIRST_BLOCK;
    if (req_type) begin
      cmd.reject     = bad_free;
      cmd.rej_status = sac_pkg::ST_BAD_FREE;
      cmd.cls        = fslab[5:2];
    end else begin
      cmd.reject     = bad_size;
      cmd.rej_status = sac_pkg::ST_BAD_SIZE;
      cmd.cls        = acls;
    end
  end

endmodule

// ===== sv/sac_queue.sv =====
module sac_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sac_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sac_pkg::cmd_t head_cmd
);

  sac_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/sac_back.sv =====
module sac_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  sac_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [21:0]   block_address,
  output logic [1:0]    status,
  output logic          slab_released
);

  typedef enum logic [3:0] {
    S_IDLE, S_META, S_SRD, S_SCHK, S_SBIT, S_AWR, S_MUL, S_FIN,
    S_DIV, S_FRD, S_FCHK, S_FWR
  } state_t;

  typedef struct packed {
    logic [sac_pkg::SLOT_W-1:0] cnt;
    logic [sac_pkg::HWM_W-1:0]  hwm;   // bitmap words in use since activation
  } meta_t;

  localparam int MEM_W = sac_pkg::SLAB_W + sac_pkg::WORD_W;

  state_t state;
  logic [sac_pkg::SLAB_W-1:0]   slab;
  logic [sac_pkg::CLS_W-1:0]    cls;
  logic [sac_pkg::WORD_W-1:0]   w;
  logic                         rd_zero;
  logic [63:0]                  word;
  logic [2:0]                   byte_idx;
  logic [sac_pkg::SLOT_W-1:0]   slot;
  logic [15:0]                  prod;
  logic [15:0]                  divd;
  logic [14:0]                  rem;
  logic [15:0]                  quo;
  logic [3:0]                   dcnt;
  logic [sac_pkg::TOTAL_SLABS-1:0] active;
  logic [sac_pkg::TOTAL_SLABS-1:0] room;

  logic [63:0] bitmap [sac_pkg::TOTAL_SLABS * 128];
  logic [63:0] mem_q;
  logic [MEM_W-1:0] mem_addr;
  logic [63:0] mem_wdata;
  logic        mem_we;

  meta_t meta_mem [sac_pkg::TOTAL_SLABS];
  meta_t meta_q;
  meta_t meta_wdata;
  logic  meta_we;
  logic [sac_pkg::SLAB_W-1:0] meta_addr;

  logic                       start;
  logic [sac_pkg::SLAB_W-1:0] base;
  logic [3:0]                 act4, room4;
  logic                       have_room, have_idle;
  logic [1:0]                 k_room, k_idle;
  logic [sac_pkg::SLAB_W-1:0] new_slab;
  logic [sac_pkg::SLOT_W-1:0] n_cur, n_cmd;
  logic [sac_pkg::STRIDE_W-1:0] stride;
  logic [63:0] word_cur;
  logic [63:0] inv;
  logic        byte_found;
  logic [2:0]  byte_sel;
  logic [7:0]  inv_byte;
  logic [2:0]  bit_sel;
  logic [15:0] rem_sh;
  logic        ge;
  logic [27:0] prod_full;
  logic [sac_pkg::SLOT_W-1:0] cnt_inc;

  assign start   = cmd_valid && !out_valid && (state == S_IDLE);
  assign cmd_pop = start;
  assign base    = {cmd.cls, 2'b00};
  assign act4    = active[base +: 4];
  assign room4   = room[base +: 4];
  assign n_cmd   = sac_pkg::slot_count(cmd.cls);
  assign n_cur   = sac_pkg::slot_count(cls);
  assign stride  = sac_pkg::stride_of(cls);
  assign word_cur = rd_zero ? 64'd0 : mem_q;
  assign inv      = ~word_cur;
  assign inv_byte = ~word[byte_idx*8 +: 8];
  assign rem_sh   = {rem, divd[15]};
  assign ge       = rem_sh >= {1'b0, stride};
  assign prod_full = 28'(slot) * 28'(stride);
  assign cnt_inc  = meta_q.cnt + 13'd1;
  assign new_slab = base + sac_pkg::SLAB_W'(k_idle);

  // lowest slab with room / lowest inactive slab of the class
  always_comb begin
    have_room = 1'b0;
    have_idle = 1'b0;
    k_room    = 2'd0;
    k_idle    = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (act4[k] && room4[k]) begin
        have_room = 1'b1;
        k_room    = 2'(k);
      end
      if (!act4[k]) begin
        have_idle = 1'b1;
        k_idle    = 2'(k);
      end
    end
  end

  // first byte with a free slot, then first free bit in that byte
  always_comb begin
    byte_found = 1'b0;
    byte_sel   = 3'd0;
    bit_sel    = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (inv[b*8 +: 8] != 8'd0) begin
        byte_found = 1'b1;
        byte_sel   = 3'(b);
      end
      if (inv_byte[b]) bit_sel = 3'(b);
    end
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_wdata  = word;
    mem_addr   = {slab, w};
    meta_we    = 1'b0;
    meta_addr  = slab;
    meta_wdata = meta_q;
    unique case (state)
      S_IDLE: begin
        mem_addr   = {new_slab, 7'd0};
        mem_wdata  = 64'd1;
        meta_addr  = new_slab;
        meta_wdata = '{cnt: n_cmd - 13'd1, hwm: 8'd1};
        if (start && !cmd.reject && !cmd.is_free && !have_room && have_idle) begin
          mem_we  = 1'b1;
          meta_we = 1'b1;
        end
      end
      S_AWR: begin
        mem_we         = 1'b1;
        meta_we        = 1'b1;
        meta_wdata.cnt = meta_q.cnt - 13'd1;
        if ({1'b0, w} == meta_q.hwm) meta_wdata.hwm = meta_q.hwm + 8'd1;
      end
      S_FRD: mem_addr = {slab, quo[12:6]};
      S_FCHK, S_FWR: begin
        mem_addr = {slab, slot[12:6]};
        if (state == S_FWR) begin
          mem_we         = 1'b1;
          meta_we        = 1'b1;
          meta_wdata.cnt = (cnt_inc >= n_cur) ? 13'd0 : cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) bitmap[mem_addr] <= mem_wdata;
    mem_q <= bitmap[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_addr] <= meta_wdata;
    meta_q <= meta_mem[meta_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      room      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cls           <= cmd.cls;
            block_address <= '0;
            slab_released <= 1'b0;
            if (cmd.reject) begin
              status    <= cmd.rej_status;
              out_valid <= 1'b1;
            end else if (!cmd.is_free) begin
              if (have_room) begin
                status <= sac_pkg::ST_OK;
                slab   <= base + sac_pkg::SLAB_W'(k_room);
                state  <= S_META;
              end else if (have_idle) begin
                status           <= sac_pkg::ST_OK;
                slab             <= new_slab;
                slot             <= '0;
                active[new_slab] <= 1'b1;
                room[new_slab]   <= (n_cmd != 13'd1);
                state            <= S_MUL;
              end else begin
                status    <= sac_pkg::ST_NO_SLAB;
                out_valid <= 1'b1;
              end
            end else if (!active[cmd.slab]) begin
              status    <= sac_pkg::ST_BAD_FREE;
              out_valid <= 1'b1;
            end else begin
              status <= sac_pkg::ST_OK;
              slab   <= cmd.slab;
              divd   <= cmd.blk_off;
              rem    <= '0;
              quo    <= '0;
              dcnt   <= '0;
              state  <= S_DIV;
            end
          end
        end
        S_META: begin
          w     <= '0;
          state <= S_SRD;
        end
        S_SRD: begin
          rd_zero <= ({1'b0, w} >= meta_q.hwm);
          state   <= S_SCHK;
        end
        S_SCHK: begin
          if (byte_found) begin
            word     <= word_cur;
            byte_idx <= byte_sel;
            state    <= S_SBIT;
          end else begin
            w     <= w + 7'd1;
            state <= S_SRD;
          end
        end
        S_SBIT: begin
          slot  <= {w, byte_idx, bit_sel};
          word  <= word | (64'd1 << {byte_idx, bit_sel});
          state <= S_AWR;
        end
        S_AWR: begin
          room[slab] <= (meta_q.cnt != 13'd1);
          state      <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod_full[15:0];
          state <= S_FIN;
        end
        S_FIN: begin
          block_address <= {slab, sac_pkg::FIRST_BLOCK + prod};
          out_valid     <= 1'b1;
          state         <= S_IDLE;
        end
        S_DIV: begin
          rem   <= ge ? 15'(rem_sh - {1'b0, stride}) : rem_sh[14:0];
          quo   <= {quo[14:0], ge};
          divd  <= {divd[14:0], 1'b0};
          dcnt  <= dcnt + 4'd1;
          if (dcnt == 4'd15) state <= S_FRD;
        end
        S_FRD: begin
          if (rem != 15'd0 || quo >= {3'd0, n_cur}) begin
            status    <= sac_pkg::ST_BAD_FREE;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            slot    <= quo[12:0];
            rd_zero <= ({1'b0, quo[12:6]} >= meta_q.hwm);
            state   <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (!word_cur[slot[5:0]]) begin
            status    <= sac_pkg::ST_BAD_FREE;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            word  <= word_cur & ~(64'd1 << slot[5:0]);
            state <= S_FWR;
          end
        end
        S_FWR: begin
          if (cnt_inc >= n_cur) begin
            active[slab]  <= 1'b0;
            room[slab]    <= 1'b0;
            slab_released <= 1'b1;
          end else begin
            room[slab] <= 1'b1;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_room_active: assert property (@(posedge clk) disable iff (rst)
    (room & ~active) == '0)
    else $error("slab with room is not active");

  a_busy_no_out: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("engine busy while result pending");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (cmd_valid && state == S_IDLE && !out_valid))
    else $error("pop outside idle");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && dcnt != 4'd15) |=> (state == S_DIV))
    else $error("divider left early");

endmodule

// ===== sv/slab_allocator_size_classes_core.sv =====
// Slab allocator with power-of-two size classes (2 to 16384 bytes, 14 classes,
// 4 slabs of 64 KiB per class). An allocate returns the first free slot in the lowest
// active slab of its class, activating a new slab when none has room; a free
// decodes slab and slot from the address and retires a slab once it is empty.
// Items are handled one at a time by the back end. A rejected request is answered
// straight from the idle state; an allocate that activates a slab writes the
// slab's first bitmap word and goes on to the address multiply; an allocate into
// an active slab scans its bitmap words in order, one single-port bitmap RAM read
// plus a check per word; a free finds its slot with the 16-step bit-serial divide
// by the slot stride. A two-entry queue lets the front accept items while the
// back end works or a result waits. No clearing pass after reset: per-slab
// word high-water marks make untouched bitmap words read as free.
module slab_allocator_size_classes_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] req_size,
  input  logic [21:0] free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] block_address,
  output logic [1:0]  status,
  output logic        slab_released
);

  sac_pkg::cmd_t in_cmd;
  sac_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          head_valid;
  logic          pop;

  // front: classify the request (size class, slab, range checks)
  sac_front u_front (
    .req_type     (req_type),
    .req_size     (req_size),
    .free_address (free_address),
    .cmd          (in_cmd)
  );

  assign in_stall = q_full;

  // short queue decoupling intake from the engine
  sac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !q_full),
    .push_cmd   (in_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: bitmap search, divide, bookkeeping, result register
  sac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (head_valid),
    .cmd           (head_cmd),
    .cmd_pop       (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .block_address (block_address),
    .status        (status),
    .slab_released (slab_released)
  );

endmodule

// ===== test/slab_allocator_checker.sv =====
`timescale 1ns / 1ps

module slab_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] req_size,
  input  logic [21:0] free_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [21:0] block_address,
  input  logic [1:0]  status,
  input  logic        slab_released,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [21:0]      addr;
    sac_pkg::status_t st;
    logic             released;
  } reply_t;

  reply_t      reply_q[$];
  logic [8191:0] slot_map [sac_pkg::TOTAL_SLABS];
  int unsigned   slab_room [sac_pkg::TOTAL_SLABS];
  bit            slab_live [sac_pkg::TOTAL_SLABS];

  assign pending = reply_q.size();

  function automatic int unsigned class_slots(int unsigned cls);
    int unsigned n;
    n = (65536 - 1024) / ((2 << cls) + 8);
    return (n > 8192) ? 8192 : n;
  endfunction

  function automatic logic [21:0] slot_addr(int unsigned slab, int unsigned cls,
                                            int unsigned slot);
    longint unsigned a;
    a = longint'(slab) * 65536 + 1024 + longint'(slot) * ((2 << cls) + 8) + 8;
    return a[21:0];
  endfunction

  function automatic reply_t allocate(logic [15:0] size);
    reply_t      r;
    int unsigned cls, n, s, slot;
    r = '{addr: '0, st: sac_pkg::ST_OK, released: 1'b0};
    cls = 0;
    if (size == 0 || size > 16384) begin
      r.st = sac_pkg::ST_BAD_SIZE;
      return r;
    end
    while ((2 << cls) < size) cls++;
    n = class_slots(cls);
    if (n == 0) begin
      r.st = sac_pkg::ST_NO_SLAB;
      return r;
    end
    // first active slab with room, lowest slot
    for (int k = 0; k < sac_pkg::SLABS_PER_CLASS; k++) begin
      s = cls * sac_pkg::SLABS_PER_CLASS + k;
      if (slab_live[s] && slab_room[s] > 0) begin
        slot = n;
        for (int b = 0; b < n; b++)
          if (!slot_map[s][b]) begin
            slot = b;
            break;
          end
        if (slot < n) begin
          slot_map[s][slot] = 1'b1;
          slab_room[s]--;
          r.addr = slot_addr(s, cls, slot);
          return r;
        end
      end
    end
    // otherwise open a fresh slab
    for (int k = 0; k < sac_pkg::SLABS_PER_CLASS; k++) begin
      s = cls * sac_pkg::SLABS_PER_CLASS + k;
      if (!slab_live[s]) begin
        slot_map[s] = '0;
        slot_map[s][0] = 1'b1;
        slab_live[s] = 1'b1;
        slab_room[s] = n - 1;
        r.addr = slot_addr(s, cls, 0);
        return r;
      end
    end
    r.st = sac_pkg::ST_NO_SLAB;
    return r;
  endfunction

  function automatic reply_t release_block(logic [21:0] addr);
    reply_t      r;
    int unsigned s, off, cls, stride, d, n, slot;
    r = '{addr: '0, st: sac_pkg::ST_BAD_FREE, released: 1'b0};
    s = addr[21:16];
    off = addr[15:0];
    if (s >= sac_pkg::TOTAL_SLABS || !slab_live[s] || off < 1032) return r;
    cls = s / sac_pkg::SLABS_PER_CLASS;
    stride = (2 << cls) + 8;
    d = off - 1032;
    n = class_slots(cls);
    if (d % stride != 0 || d / stride >= n) return r;
    slot = d / stride;
    if (!slot_map[s][slot]) return r;
    slot_map[s][slot] = 1'b0;
    slab_room[s]++;
    r.st = sac_pkg::ST_OK;
    if (slab_room[s] >= n) begin
      slab_live[s] = 1'b0;
      slab_room[s] = 0;
      r.released = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reply_t w;
    if (rst) begin
      fail_count = 0;
      reply_q.delete();
      for (int s = 0; s < sac_pkg::TOTAL_SLABS; s++) begin
        slot_map[s] = '0;
        slab_room[s] = 0;
        slab_live[s] = 1'b0;
      end
    end else begin
      if (in_valid && !in_stall)
        reply_q.push_back(req_type ? release_block(free_address) : allocate(req_size));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("results outstanding", 1, 0);
        end else begin
          w = reply_q.pop_front();
          if (block_address !== w.addr) report_mismatch("block_address", block_address, w.addr);
          if (status !== w.st) report_mismatch("status", status, w.st);
          if (slab_released !== w.released)
            report_mismatch("slab_released", slab_released, w.released);
        end
      end
    end
  end

endmodule

// ===== test/tb_slab_allocator_size_classes_core.sv =====
`timescale 1ns / 1ps

module tb_slab_allocator_size_classes_core;

  localparam int RANDOM_ITEMS = 1925;
  localparam int QUIET_FROM   = 1700;   // no idling on either side past this item

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] req_size;
  logic [21:0] free_address;
  logic        out_valid;
  logic        out_stall;
  logic [21:0] block_address;
  logic [1:0]  status;
  logic        slab_released;
  int          fail_count;
  int          pending;

  // addresses handed out by the block, candidates for well-formed frees
  logic [21:0] live_blocks[$];
  bit          quiet;
  int          stall_left;

  slab_allocator_size_classes_core i_dut (
    .clk, .rst, .in_valid, .in_stall, .req_type, .req_size, .free_address,
    .out_valid, .out_stall, .block_address, .status, .slab_released
  );

  slab_allocator_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .req_type, .req_size, .free_address,
    .out_valid, .out_stall, .block_address, .status, .slab_released,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // harvest allocated addresses
  always @(posedge clk)
    if (!rst && out_valid && !out_stall && status == sac_pkg::ST_OK && block_address != 0)
      live_blocks.push_back(block_address);

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && !rst && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one item at the current falling edge and hold it until taken.
  task automatic send_item(logic kind, logic [15:0] size, logic [21:0] addr);
    in_valid     <= 1'b1;
    req_type     <= kind;
    req_size     <= size;
    free_address <= addr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic go_idle(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // start of slot k in class-13 slab s
  function automatic logic [21:0] top_class_block(int s, int k);
    return 22'(s * 65536 + 1032 + k * 16392);
  endfunction

  function automatic logic [15:0] size_in_class(int cls);
    return 16'($urandom_range((1 << cls) + 1, 2 << cls));
  endfunction

  initial begin
    int          r, cls, s, idx;
    logic [21:0] a;
    quiet        = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = 1'b0;
    req_size     = '0;
    free_address = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: size limits, class 13 exhaustion, slab retire, bad frees
    send_item(1'b0, 16'd0, 22'h3FFFFF);
    send_item(1'b0, 16'd1, '0);
    send_item(1'b0, 16'd2, '0);
    send_item(1'b0, 16'd16385, '0);
    send_item(1'b0, 16'hFFFF, '0);
    for (int k = 0; k < 13; k++) send_item(1'b0, 16'd16384, '0);   // 12 fit, then no slab
    for (int k = 0; k < 3; k++) send_item(1'b1, '0, top_class_block(52, k));   // last retires
    send_item(1'b1, 16'hFFFF, top_class_block(53, 0));
    send_item(1'b1, '0, top_class_block(53, 0));          // double free
    send_item(1'b1, '0, 22'(53 * 65536 + 100));           // in header
    send_item(1'b1, '0, 22'h3FFFFF);                      // past slab area
    send_item(1'b1, '0, 22'(20 * 65536 + 1032));          // inactive slab
    send_item(1'b1, '0, top_class_block(53, 1) + 22'd1);  // misaligned

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FROM);
      if (!quiet && $urandom_range(0, 9) == 0) go_idle($urandom_range(1, 19));
      if (i == RANDOM_ITEMS / 2) begin
        // drain the block completely before continuing
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (live_blocks.size() > 0 && (r < 40 || live_blocks.size() > 150)) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[idx];
        live_blocks.delete(idx);
        send_item(1'b1, 16'($urandom), a);
      end else if (r < 50) begin
        case ($urandom_range(0, 4))
          0: a = 22'($urandom);
          1: a = (live_blocks.size() > 0)
                 ? live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                   + 22'($urandom_range(1, 7))
                 : 22'($urandom);
          2: a = 22'($urandom_range(0, 55) * 65536 + $urandom_range(0, 1031));
          3: a = 22'(3670016 + $urandom_range(0, 524287));
          default: begin
            s = $urandom_range(0, 55);
            cls = s / sac_pkg::SLABS_PER_CLASS;
            a = 22'(s * 65536 + 1032
                    + $urandom_range(0, 64512 / ((2 << cls) + 8) + 1) * ((2 << cls) + 8));
          end
        endcase
        send_item(1'b1, 16'($urandom), a);
      end else if (r < 94) begin
        // large classes half the time so slabs fill and run out
        cls = ($urandom_range(0, 1) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 13);
        send_item(1'b0, size_in_class(cls), 22'($urandom));
      end else begin
        send_item(1'b0, 16'($urandom), 22'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
